// File: rtl/bps_pkg.sv
// Beep pattern sequencer package: item types, reset constants, pattern tables.
// No dependencies; used by bps_seq and beep_pattern_sequencer_top.
package bps_pkg;

   localparam int unsigned GapWidth  = 8;
   localparam int unsigned HzWidth   = 12;
   localparam int unsigned PhaseWidth = 3;

   localparam logic [GapWidth-1:0] GAP_RESET = 8'd40;

   typedef enum logic [0:0] {
      ACT_TICK  = 1'b0,
      ACT_START = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      PAT_CLICK   = 2'd0,
      PAT_CONFIRM = 2'd1,
      PAT_GOAL    = 2'd2,
      PAT_OFF     = 2'd3
   } pattern_type;

   typedef struct packed {
      logic       action;
      logic [1:0] pattern;
   } req_item_type;

   typedef struct packed {
      logic               tone_on;
      logic [HzWidth-1:0] tone_hz;
      logic               busy_res;
   } rsp_item_type;

   typedef struct packed {
      logic                step;
      logic [GapWidth-1:0] gap_ms;
   } seq_ctrl_type;

   function automatic logic [1:0] note_count(input logic [1:0] pat);
      logic [1:0] n;
      unique case (pattern_type'(pat))
         PAT_CLICK:   n = 2'd1;
         PAT_CONFIRM: n = 2'd2;
         PAT_GOAL:    n = 2'd3;
         PAT_OFF:     n = 2'd3;
         default:     n = 2'd1;
      endcase
      return n;
   endfunction

   function automatic logic [GapWidth-1:0] note_len(input logic [1:0] pat);
      logic [GapWidth-1:0] n;
      unique case (pattern_type'(pat))
         PAT_CLICK:   n = 8'd30;
         PAT_CONFIRM: n = 8'd100;
         PAT_GOAL:    n = 8'd120;
         PAT_OFF:     n = 8'd140;
         default:     n = 8'd30;
      endcase
      return n;
   endfunction

   function automatic logic [HzWidth-1:0] note_hz(input logic [1:0] pat, input logic [1:0] idx);
      logic [HzWidth-1:0] f;
      f = 12'd2000;
      unique case (pattern_type'(pat))
         PAT_CLICK: f = 12'd2000;
         PAT_CONFIRM: begin
            if (idx == 2'd0) f = 12'd1800;
            else             f = 12'd2400;
         end
         PAT_GOAL: begin
            if (idx == 2'd0)      f = 12'd1500;
            else if (idx == 2'd1) f = 12'd2000;
            else                  f = 12'd2500;
         end
         PAT_OFF: begin
            if (idx == 2'd0)      f = 12'd2500;
            else if (idx == 2'd1) f = 12'd2000;
            else                  f = 12'd1500;
         end
         default: f = 12'd2000;
      endcase
      return f;
   endfunction

endpackage

// File: rtl/bps_req_if.sv
// Request channel interface: valid/ready handshake with action and pattern.
// Depends on nothing.
interface bps_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [1:0] pattern;

   modport source (output valid, output action, output pattern, input ready);
   modport sink   (input valid, input action, input pattern, output ready);
endinterface

// File: rtl/bps_rsp_if.sv
// Response channel interface: valid/ready handshake with tone and busy status.
// Depends on nothing.
interface bps_rsp_if;
   logic        valid;
   logic        ready;
   logic        tone_on;
   logic [11:0] tone_hz;
   logic        busy_res;

   modport source (output valid, output tone_on, output tone_hz, output busy_res, input ready);
   modport sink   (input valid, input tone_on, input tone_hz, input busy_res, output ready);
endinterface

// File: rtl/bps_seq.sv
// Pattern sequencer state and single-pass next-state logic.
// Depends on bps_pkg.
module bps_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  bps_pkg::seq_ctrl_type ctrl,
   input  bps_pkg::req_item_type item,
   output bps_pkg::rsp_item_type result
);
   import bps_pkg::*;

   logic                  playing_ff, playing_in;
   logic [1:0]            pat_ff, pat_in;
   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic [GapWidth-1:0]   wait_ff, wait_in;
   logic                  tone_ff, tone_in;
   logic [HzWidth-1:0]    freq_ff, freq_in;

   logic [GapWidth-1:0]   wait_dec;
   logic [3:0]            total;
   logic [1:0]            idx;

   always_comb begin
      playing_in = playing_ff;
      pat_in     = pat_ff;
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      tone_in    = tone_ff;
      freq_in    = freq_ff;
      wait_dec   = (wait_ff != '0) ? wait_ff - 8'd1 : wait_ff;
      total      = {1'b0, note_count(pat_ff), 1'b0};
      idx        = (phase_ff[2:1] > 2'd2) ? 2'd2 : phase_ff[2:1];

      if (ctrl.step) begin
         if (action_type'(item.action) == ACT_START) begin
            if (pattern_type'(item.pattern) == PAT_CLICK && playing_ff) begin
               tone_in = 1'b0;
               freq_in = '0;
            end
            pat_in     = item.pattern;
            phase_in   = '0;
            playing_in = 1'b1;
            wait_in    = '0;
         end else if (playing_ff) begin
            wait_in = wait_dec;
            if (wait_dec == '0) begin
               if ({1'b0, phase_ff} >= total) begin
                  tone_in    = 1'b0;
                  freq_in    = '0;
                  playing_in = 1'b0;
                  pat_in     = '0;
                  phase_in   = '0;
                  wait_in    = '0;
               end else begin
                  if (!phase_ff[0]) begin
                     tone_in = 1'b1;
                     freq_in = note_hz(pat_ff, idx);
                     wait_in = note_len(pat_ff);
                  end else begin
                     tone_in = 1'b0;
                     freq_in = '0;
                     wait_in = ctrl.gap_ms;
                  end
                  phase_in = phase_ff + 3'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff <= 1'b0;
         pat_ff     <= '0;
         phase_ff   <= '0;
         wait_ff    <= '0;
         tone_ff    <= 1'b0;
         freq_ff    <= '0;
      end else begin
         playing_ff <= playing_in;
         pat_ff     <= pat_in;
         phase_ff   <= phase_in;
         wait_ff    <= wait_in;
         tone_ff    <= tone_in;
         freq_ff    <= freq_in;
      end
   end

   assign result.tone_on  = tone_in;
   assign result.tone_hz  = tone_in ? freq_in : '0;
   assign result.busy_res = playing_in;

endmodule

// File: rtl/beep_pattern_sequencer_top.sv
// Beep pattern sequencer top level: input register, sequencer, result register, gap CSR.
// Depends on bps_pkg, bps_req_if, bps_rsp_if and bps_seq.
//
//   channel  dir  handshake        payload
//   req_ch   in   valid/ready      action, pattern
//   rsp_ch   out  valid/ready      tone_on, tone_hz, busy_res
//   csr      in   csr_wr_en        csr_wr_data = gap_ms
//
// One item per cycle sustained while the result is taken; each accepted item is held in the input register
// until it steps the sequencer straight into the result register.
// Synchronous active-high reset; gap_ms resets to 40 ms.
// A stalled result holds while the input register still takes one more item.
module beep_pattern_sequencer_top (
   input  logic                       clock,
   input  logic                       reset,
   bps_req_if.sink                    req_ch,
   bps_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [bps_pkg::GapWidth-1:0] csr_wr_data
);
   import bps_pkg::*;

   logic                in_vld_ff, in_vld_in;
   req_item_type        in_data_ff;
   logic                rsp_vld_ff, rsp_vld_in;
   rsp_item_type        rsp_data_ff;
   logic [GapWidth-1:0] gap_ff, gap_in;

   logic                advance;
   logic                req_fire;
   seq_ctrl_type        ctrl;
   rsp_item_type        result;

   assign advance      = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = !in_vld_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign ctrl.step    = in_vld_ff && advance;
   assign ctrl.gap_ms  = gap_ff;

   assign in_vld_in  = req_fire ? 1'b1 : (ctrl.step ? 1'b0 : in_vld_ff);
   assign rsp_vld_in = ctrl.step ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_vld_ff);
   assign gap_in     = csr_wr_en ? csr_wr_data : gap_ff;

   bps_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .item   (in_data_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         gap_ff     <= GAP_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         gap_ff     <= gap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff.action  <= req_ch.action;
         in_data_ff.pattern <= req_ch.pattern;
      end
      if (ctrl.step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid    = rsp_vld_ff;
   assign rsp_ch.tone_on  = rsp_data_ff.tone_on;
   assign rsp_ch.tone_hz  = rsp_data_ff.tone_hz;
   assign rsp_ch.busy_res = rsp_data_ff.busy_res;

endmodule

// File: rtl/bps_checker.sv
// Port-level checker for the beep pattern sequencer, bound to the top level.
// Depends on beep_pattern_sequencer_top.
module bps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_tone_on,
   input logic [11:0] rsp_tone_hz,
   input logic        rsp_busy_res
);

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_tone_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tone_on |-> rsp_busy_res)
      else $error("tone on while not busy");

   a_silent_zero_hz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tone_on |-> rsp_tone_hz == 12'd0)
      else $error("nonzero frequency while silent");

   a_tone_freq_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tone_on |-> (rsp_tone_hz == 12'd1500 || rsp_tone_hz == 12'd1800 ||
         rsp_tone_hz == 12'd2000 || rsp_tone_hz == 12'd2400 || rsp_tone_hz == 12'd2500))
      else $error("tone frequency not in the note set");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tone_on) &&
         $stable(rsp_tone_hz) && $stable(rsp_busy_res))
      else $error("stalled result changed");

endmodule

bind beep_pattern_sequencer_top bps_checker u_bps_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_tone_on  (rsp_ch.tone_on),
   .rsp_tone_hz  (rsp_ch.tone_hz),
   .rsp_busy_res (rsp_ch.busy_res)
);
